// ===== rtl/htx_pkg.sv =====
package htx_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 8;
  localparam int unsigned RES_PER_REQ     = 4;
  localparam int unsigned MAX_CHARS_W     = 16;

  localparam logic [MAX_CHARS_W-1:0] MAX_CHARS_RST = 16'd4095;

  typedef logic [$clog2(RES_PER_REQ+1)-1:0] htx_rcnt_t;

  typedef struct packed {
    logic                   inside_tag;
    logic                   inside_script;
    logic                   inside_style;
    logic                   prev_space;
    logic [2:0]             tag_pos;
    logic [2:0]             tag_cand;
    logic [2:0]             ent_pos;
    logic [2:0]             ent_cand;
    logic [MAX_CHARS_W-1:0] emitted;
    logic                   stopped;
  } htx_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       eot;
  } htx_res_t;

  localparam htx_state_t STATE_RST = '0;

endpackage

// ===== rtl/htx_step.sv =====
module htx_step (
  input  logic [7:0]                                  text_byte,
  input  logic                                        end_of_input,
  input  logic [htx_pkg::MAX_CHARS_W-1:0]             max_chars,
  input  htx_pkg::htx_state_t                         state,
  output htx_pkg::htx_state_t                         state_nxt,
  output htx_pkg::htx_res_t [htx_pkg::RES_PER_REQ-1:0] res,
  output htx_pkg::htx_rcnt_t                          res_n
);
  import htx_pkg::*;

  localparam int unsigned RIDX_W = $clog2(RES_PER_REQ);
  localparam htx_rcnt_t   RCNT_MAX = htx_rcnt_t'(RES_PER_REQ);

  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_L      = "l";
  localparam logic [7:0] CH_G      = "g";
  localparam logic [7:0] CH_A      = "a";
  localparam logic [7:0] CH_M      = "m";
  localparam logic [7:0] CH_P      = "p";
  localparam logic [7:0] CH_T      = "t";
  localparam logic [7:0] CH_UC_A   = "A";
  localparam logic [7:0] CH_UC_Z   = "Z";
  localparam logic [7:0] CASE_OFFS = 8'd32;

  localparam logic [2:0] SCRIPT_LEN = 3'd6;
  localparam logic [2:0] STYLE_LEN  = 3'd5;

  localparam int unsigned CAND_SCRIPT = 0;
  localparam int unsigned CAND_STYLE  = 1;
  localparam int unsigned CAND_CLOSE  = 2;
  localparam logic [2:0]  CAND_OPEN_INIT = 3'b011;

  localparam logic [2:0] ENT_NONE = 3'b000;
  localparam logic [2:0] ENT_LT   = 3'b001;
  localparam logic [2:0] ENT_GT   = 3'b010;
  localparam logic [2:0] ENT_AMP  = 3'b100;

  typedef struct packed {
    logic [1:0]      n;
    logic [2:0][7:0] data;
  } flush_t;

  typedef struct packed {
    htx_state_t st;
    logic       emit;
    logic [7:0] data;
  } plain_t;

  function automatic logic [7:0] script_char(input logic [2:0] pos);
    case (pos)
      3'd0:    script_char = "s";
      3'd1:    script_char = "c";
      3'd2:    script_char = "r";
      3'd3:    script_char = "i";
      3'd4:    script_char = "p";
      3'd5:    script_char = "t";
      default: script_char = CH_NUL;
    endcase
  endfunction

  function automatic logic [7:0] style_char(input logic [2:0] pos);
    case (pos)
      3'd0:    style_char = "s";
      3'd1:    style_char = "t";
      3'd2:    style_char = "y";
      3'd3:    style_char = "l";
      3'd4:    style_char = "e";
      default: style_char = CH_NUL;
    endcase
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    to_lower = (b >= CH_UC_A && b <= CH_UC_Z) ? b + CASE_OFFS : b;
  endfunction

  // literal bytes of a pending entity prefix
  function automatic flush_t flush_seq(input htx_state_t s);
    flush_t f;
    logic   amp;
    f   = '0;
    amp = (s.ent_cand & ENT_AMP) != ENT_NONE;
    if (s.ent_pos != 3'd0) begin
      if (s.ent_pos == 3'd1 || !amp) begin
        f.data[f.n] = CH_AMP;
        f.n = f.n + 2'd1;
      end
      if (s.ent_pos >= 3'd2) begin
        if ((s.ent_cand & ENT_LT) != ENT_NONE) begin
          f.data[f.n] = CH_L;
          f.n = f.n + 2'd1;
        end else if ((s.ent_cand & ENT_GT) != ENT_NONE) begin
          f.data[f.n] = CH_G;
          f.n = f.n + 2'd1;
        end else if (amp) begin
          f.data[f.n] = CH_A;
          f.n = f.n + 2'd1;
        end
      end
      if (s.ent_pos >= 3'd3) begin
        f.data[f.n] = amp ? CH_M : CH_T;
        f.n = f.n + 2'd1;
      end
      if (s.ent_pos >= 3'd4 && amp) begin
        f.data[f.n] = CH_P;
        f.n = f.n + 2'd1;
      end
    end
    return f;
  endfunction

  function automatic htx_state_t flush_state(input htx_state_t s);
    htx_state_t r;
    r = s;
    if (s.ent_pos != 3'd0) begin
      r.prev_space = 1'b0;
    end
    r.ent_pos  = 3'd0;
    r.ent_cand = ENT_NONE;
    return r;
  endfunction

  function automatic plain_t plain_step(input htx_state_t s, input logic [7:0] b);
    plain_t     r;
    logic [7:0] lc;
    logic       closing;
    logic [2:0] pos;
    r       = '0;
    r.st    = s;
    lc      = to_lower(b);
    closing = s.tag_cand[CAND_CLOSE];
    pos     = s.tag_pos;
    if (!s.inside_tag && b == CH_LT) begin
      r.st.inside_tag = 1'b1;
      r.st.tag_pos    = 3'd0;
      r.st.tag_cand   = CAND_OPEN_INIT;
    end else if (s.inside_tag) begin
      if (r.st.tag_cand[CAND_SCRIPT] || r.st.tag_cand[CAND_STYLE]) begin
        if (pos == 3'd0 && !closing && b == CH_SLASH) begin
          r.st.tag_cand[CAND_CLOSE] = 1'b1;
        end else begin
          if (r.st.tag_cand[CAND_SCRIPT] && !(pos < SCRIPT_LEN && lc == script_char(pos))) begin
            r.st.tag_cand[CAND_SCRIPT] = 1'b0;
          end
          if (r.st.tag_cand[CAND_STYLE] && !(pos < STYLE_LEN && lc == style_char(pos))) begin
            r.st.tag_cand[CAND_STYLE] = 1'b0;
          end
          pos = pos + 3'd1;
          r.st.tag_pos = pos;
          if (r.st.tag_cand[CAND_SCRIPT] && pos == SCRIPT_LEN) begin
            r.st.inside_script = !closing;
            r.st.tag_cand[CAND_SCRIPT] = 1'b0;
          end
          if (r.st.tag_cand[CAND_STYLE] && pos == STYLE_LEN) begin
            r.st.inside_style = !closing;
            r.st.tag_cand[CAND_STYLE] = 1'b0;
          end
        end
      end
      if (b == CH_GT) begin
        r.st.inside_tag = 1'b0;
        r.st.tag_cand   = 3'd0;
        r.st.tag_pos    = 3'd0;
      end
    end else if (!(s.inside_script || s.inside_style)) begin
      if (b == CH_CR || b == CH_LF || b == CH_TAB) begin
        if (!s.prev_space) begin
          r.emit = 1'b1;
          r.data = CH_LF;
        end
        r.st.prev_space = 1'b1;
      end else if (b == CH_AMP) begin
        r.st.ent_pos  = 3'd1;
        r.st.ent_cand = ENT_NONE;
      end else if (b == CH_SPACE) begin
        if (!s.prev_space) begin
          r.emit = 1'b1;
          r.data = CH_SPACE;
        end
        r.st.prev_space = 1'b1;
      end else begin
        r.emit = 1'b1;
        r.data = b;
        r.st.prev_space = 1'b0;
      end
    end
    return r;
  endfunction

  htx_state_t                         s;
  flush_t                             pre;
  flush_t                             post;
  plain_t                             pl;
  logic                               stop_now;
  logic                               done;
  logic                               over;
  logic [RES_PER_REQ-1:0][7:0]        cand;
  htx_rcnt_t                          ncand;
  htx_rcnt_t                          n;
  logic [MAX_CHARS_W-1:0]             avail;

  always_comb begin
    s        = state;
    pre      = '0;
    post     = '0;
    pl       = '0;
    done     = 1'b0;
    stop_now = state.stopped || (state.emitted >= max_chars);
    s.stopped = stop_now;

    if (!stop_now) begin
      if (text_byte == CH_NUL) begin
        pre = flush_seq(s);
        s   = flush_state(s);
        s.stopped = 1'b1;
      end else if (s.ent_pos != 3'd0) begin
        if (s.ent_pos == 3'd1) begin
          if (text_byte == CH_L) begin
            s.ent_cand = ENT_LT;
            s.ent_pos  = 3'd2;
            done       = 1'b1;
          end else if (text_byte == CH_G) begin
            s.ent_cand = ENT_GT;
            s.ent_pos  = 3'd2;
            done       = 1'b1;
          end else if (text_byte == CH_A) begin
            // "&a" commits the ampersand right away
            pre.n       = 2'd1;
            pre.data[0] = CH_AMP;
            s.prev_space = 1'b0;
            s.ent_cand  = ENT_AMP;
            s.ent_pos   = 3'd2;
            done        = 1'b1;
          end
        end else if (s.ent_cand == ENT_LT || s.ent_cand == ENT_GT) begin
          if (s.ent_pos == 3'd2 && text_byte == CH_T) begin
            s.ent_pos = 3'd3;
            done      = 1'b1;
          end else if (s.ent_pos == 3'd3 && text_byte == CH_SEMI) begin
            pre.n       = 2'd1;
            pre.data[0] = (s.ent_cand == ENT_LT) ? CH_LT : CH_GT;
            s.prev_space = 1'b0;
            s.ent_pos   = 3'd0;
            s.ent_cand  = ENT_NONE;
            done        = 1'b1;
          end
        end else if (s.ent_cand == ENT_AMP) begin
          if ((s.ent_pos == 3'd2 && text_byte == CH_M) ||
              (s.ent_pos == 3'd3 && text_byte == CH_P)) begin
            s.ent_pos = s.ent_pos + 3'd1;
            done      = 1'b1;
          end else if (s.ent_pos == 3'd4 && text_byte == CH_SEMI) begin
            s.ent_pos  = 3'd0;
            s.ent_cand = ENT_NONE;
            done       = 1'b1;
          end
        end
        if (!done) begin
          pre = flush_seq(s);
          s   = flush_state(s);
          pl  = plain_step(s, text_byte);
          s   = pl.st;
        end
      end else begin
        pl = plain_step(s, text_byte);
        s  = pl.st;
      end
    end

    if (end_of_input) begin
      post = flush_seq(s);
      s    = flush_state(s);
    end

    // ordered list of bytes the step asks to emit
    cand  = '0;
    ncand = '0;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < pre.n && ncand < RCNT_MAX) begin
        cand[ncand[RIDX_W-1:0]] = pre.data[i];
        ncand = ncand + htx_rcnt_t'(1);
      end
    end
    if (pl.emit && ncand < RCNT_MAX) begin
      cand[ncand[RIDX_W-1:0]] = pl.data;
      ncand = ncand + htx_rcnt_t'(1);
    end
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < post.n && ncand < RCNT_MAX) begin
        cand[ncand[RIDX_W-1:0]] = post.data[i];
        ncand = ncand + htx_rcnt_t'(1);
      end
    end

    // output limit
    avail = (max_chars > state.emitted) ? max_chars - state.emitted : '0;
    if (stop_now) begin
      n    = '0;
      over = 1'b0;
    end else if (MAX_CHARS_W'(ncand) <= avail) begin
      n    = ncand;
      over = 1'b0;
    end else begin
      n    = htx_rcnt_t'(avail);
      over = 1'b1;
    end
    s.emitted = state.emitted + MAX_CHARS_W'(n);
    s.stopped = s.stopped | over;

    state_nxt = end_of_input ? STATE_RST : s;

    for (int k = 0; k < RES_PER_REQ; k++) begin
      res[k].data  = (htx_rcnt_t'(k) < n) ? cand[k] : CH_NUL;
      res[k].valid = htx_rcnt_t'(k) < n;
      res[k].eot   = end_of_input &&
                     ((n != '0) ? (htx_rcnt_t'(k) == n - htx_rcnt_t'(1)) : (k == 0));
    end
    res_n = (end_of_input && n == '0) ? htx_rcnt_t'(1) : n;
  end

endmodule

// ===== rtl/htx_outq.sv =====
module htx_outq #(
  parameter int unsigned DEPTH = htx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  htx_pkg::htx_rcnt_t                          push_n,
  input  htx_pkg::htx_res_t [htx_pkg::RES_PER_REQ-1:0] push_data,
  output logic                                        room,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output htx_pkg::htx_res_t                           head
);
  import htx_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned SUM_W = PTR_W + 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  htx_res_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             pop;

  function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W-1:0] ptr,
                                            input logic [SUM_W-1:0] k);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, ptr} + k;
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  assign pop       = out_valid && !out_stall;
  assign out_valid = cnt_r != '0;
  assign head      = mem_r[rd_ptr_r];
  assign room      = cnt_r <= CNT_W'(DEPTH - RES_PER_REQ);
  assign cnt_nxt   = cnt_r + CNT_W'(push_n) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    for (int k = 0; k < RES_PER_REQ; k++) begin
      if (htx_rcnt_t'(k) < push_n) begin
        mem_r[wrap(wr_ptr_r, SUM_W'(k))] <= push_data[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wrap(wr_ptr_r, SUM_W'(push_n));
      if (pop) begin
        rd_ptr_r <= wrap(rd_ptr_r, SUM_W'(1));
      end
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("output queue over capacity");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    !room |-> push_n == '0)
    else $error("push into output queue without room");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> cnt_r == $past(cnt_r) + CNT_W'($past(push_n)) - CNT_W'($past(pop)))
    else $error("output queue count out of step");

endmodule

// ===== rtl/html_text_extractor_unit.sv =====
// HTML visible-text extractor.
// Input channel (in_valid / in_stall): one raw HTML byte per request, with
// in_end_of_input marking the last byte of a document. Output channel
// (out_valid / out_stall): one result per request, carrying a text byte,
// its byte_valid flag and end_of_text on the last result of a document.
// A byte can produce zero to four results; a last byte always produces at
// least one (a bare end marker if no text came out of it).
// A byte accepted into the input register is evaluated there and its
// results are written into the output queue; the queue head is offered
// to the receiver. Throughput: one input byte per cycle while the output
// queue has room for four results; results leave at one per cycle while
// the receiver does not stall, so the sustained rate is set by the output
// queue drain.
// in_stall comes from registers only and rises when the input register is
// full and the output queue lacks room; a stalled receiver fills the queue
// and then holds the input side.
// cfg_wr_en / cfg_wr_data set max_output_chars; write it only while idle.
// Reset (rst_n low, synchronous) empties the queue, clears the parse state
// and sets max_output_chars to 4095.
module html_text_extractor_unit #(
  parameter int unsigned QUEUE_DEPTH = htx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_text_byte,
  input  logic                              in_end_of_input,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_out_byte,
  output logic                              out_byte_valid,
  output logic                              out_end_of_text,
  input  logic                              cfg_wr_en,
  input  logic [htx_pkg::MAX_CHARS_W-1:0]   cfg_wr_data
);
  import htx_pkg::*;

  logic [MAX_CHARS_W-1:0]              max_r;
  logic                                req_v_r;
  logic                                req_v_nxt;
  logic [7:0]                          req_byte_r;
  logic                                req_last_r;
  htx_state_t                          state_r;
  htx_state_t                          state_nxt;
  htx_res_t [RES_PER_REQ-1:0]          step_res;
  htx_rcnt_t                           step_res_n;
  htx_rcnt_t                           push_n;
  htx_res_t                            head;
  logic                                room;
  logic                                fire;
  logic                                accept;

  assign fire      = req_v_r && room;
  assign in_stall  = req_v_r && !room;
  assign accept    = in_valid && !in_stall;
  assign req_v_nxt = accept || (req_v_r && !fire);
  assign push_n    = fire ? step_res_n : '0;

  htx_step u_step (
    .text_byte    (req_byte_r),
    .end_of_input (req_last_r),
    .max_chars    (max_r),
    .state        (state_r),
    .state_nxt    (state_nxt),
    .res          (step_res),
    .res_n        (step_res_n)
  );

  htx_outq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push_data (step_res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_out_byte    = head.data;
  assign out_byte_valid  = head.valid;
  assign out_end_of_text = head.eot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r   <= MAX_CHARS_RST;
      req_v_r <= 1'b0;
      state_r <= STATE_RST;
    end else begin
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
      req_v_r <= req_v_nxt;
      if (fire) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_byte_r <= in_text_byte;
      req_last_r <= in_end_of_input;
    end
  end

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && req_last_r) |-> step_res_n != '0)
    else $error("last byte produced no result");

  a_last_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && req_last_r) |=> state_r == STATE_RST)
    else $error("state not cleared after end of document");

  a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> step_res_n <= htx_rcnt_t'(RES_PER_REQ))
    else $error("too many results for one byte");

endmodule
